/* hw/rtl/vang_pkg.sv */
// ----------------------------------------------------------------------------
// vang_pkg: shared constants for the 2D vector angle pipeline
// Fixed-point formats, unit latencies and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vang_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // result formats
    localparam int COS_W        = 16;
    localparam int CS_W         = 15;
    localparam int TAN_W        = 32;
    localparam int ANGLE_W      = 16;
    localparam int M_TDATA_W    = 80;
    localparam int M_TUSER_W    = 2;

    // ratio and tangent scaling
    localparam int COS_SHIFT    = 30;
    localparam int TAN_SHIFT    = 17;
    localparam int DIV_QBITS    = 34;
    localparam int ROOT_W       = 16;

    localparam logic [TAN_W-1:0] TAN_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [TAN_W-1:0] TAN_NEG_MAX = 32'h8000_0000;

    // CORDIC
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_PRESHIFT = 10;
    localparam int CORDIC_XW       = 28;
    localparam int CORDIC_ZW       = 25;
    localparam int ANGLE_ZW        = 24;
    localparam int ATAN_W          = 23;
    localparam int QUARTER_Q16     = 90 * 65536;
    localparam int HALF_Q16        = 180 * 65536;
    localparam int ANGLE_ROUND     = 128;
    localparam int ANGLE_FRAC_DROP = 8;

    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    // unit latencies in cycles
    localparam int MUL_LAT    = 2;
    localparam int DIV_LAT    = DIV_QBITS + 1;
    localparam int ROOT_LAT   = ROOT_W;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;

endpackage

/* hw/rtl/vang_delay.sv */
// ----------------------------------------------------------------------------
// vang_delay: payload delay line
// Shifts a word through DEPTH registers whenever the pipeline advances.
// ----------------------------------------------------------------------------
module vang_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

/* hw/rtl/vang_mul_split.sv */
// ----------------------------------------------------------------------------
// vang_mul_split: two-stage unsigned multiplier
// Splits both operands into halves, registers four partial products, sums.
// ----------------------------------------------------------------------------
module vang_mul_split #(
    parameter int HW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [2*HW-1:0] a,
    input  logic [2*HW-1:0] b,
    output logic [4*HW-1:0] p
);

    logic [2*HW-1:0] pp_ll_reg;
    logic [2*HW-1:0] pp_lh_reg;
    logic [2*HW-1:0] pp_hl_reg;
    logic [2*HW-1:0] pp_hh_reg;
    logic [4*HW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= (2*HW)'(a[HW-1:0])    * (2*HW)'(b[HW-1:0]);
            pp_lh_reg <= (2*HW)'(a[HW-1:0])    * (2*HW)'(b[2*HW-1:HW]);
            pp_hl_reg <= (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[HW-1:0]);
            pp_hh_reg <= (2*HW)'(a[2*HW-1:HW]) * (2*HW)'(b[2*HW-1:HW]);
            p_reg     <= {pp_hh_reg, pp_ll_reg}
                       + ((4*HW)'(pp_lh_reg) << HW)
                       + ((4*HW)'(pp_hl_reg) << HW);
        end
    end

    assign p = p_reg;

endmodule

/* hw/rtl/vang_div.sv */
// ----------------------------------------------------------------------------
// vang_div: pipelined restoring divider
// One quotient bit per stage; flags a quotient that needs more than QB bits.
// ----------------------------------------------------------------------------
module vang_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = 34
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QB-1:0] q,
    output logic          ovf
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [NW-1:0] r_reg   [QB+1];
    logic [DW-1:0] d_reg   [QB];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= n;
            d_reg[0]   <= d;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CW'(n) >= (CW'(d) << QB);
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_stage
        localparam int K = QB - j;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = CW'(d_reg[j-1]) << K;
        assign take  = CW'(r_reg[j-1]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j]   <= take ? NW'(CW'(r_reg[j-1]) - trial) : r_reg[j-1];
                q_reg[j]   <= q_reg[j-1] | (take ? (QB'(1) << K) : QB'(0));
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end

        if (j < QB) begin : g_dpass
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[j] <= d_reg[j-1];
                end
            end
        end
    end

    assign q   = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

/* hw/rtl/vang_isqrt.sv */
// ----------------------------------------------------------------------------
// vang_isqrt: pipelined integer square root
// Settles one root bit per stage, keeping the running remainder.
// ----------------------------------------------------------------------------
module vang_isqrt #(
    parameter int RW = 16
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RW-1:0] v,
    output logic [RW-1:0]   root
);

    logic [2*RW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rem_in   [RW];
    logic [RW-1:0]   root_in  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int B = RW - 1 - s;
        logic [2*RW:0] test;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in[s]  = v;
            assign root_in[s] = '0;
        end else begin : g_next
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
        end

        assign test = ((2*RW+1)'(root_in[s]) << (B + 1)) + ((2*RW+1)'(1) << (2 * B));
        assign take = (2*RW+1)'(rem_in[s]) >= test;

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[s] <= root_in[s] | (take ? (RW'(1) << B) : RW'(0));
                if (s < RW - 1) begin
                    rem_reg[s] <= take ? (2*RW)'((2*RW+1)'(rem_in[s]) - test)
                                       : rem_in[s];
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* hw/rtl/vang_cordic.sv */
// ----------------------------------------------------------------------------
// vang_cordic: vectoring CORDIC angle unit
// One rotation per stage, then clamp of the angle to 0..90 degrees Q8.16.
// ----------------------------------------------------------------------------
module vang_cordic (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [vang_pkg::CS_W-1:0]     c,
    input  logic [vang_pkg::CS_W-1:0]     s,
    output logic [vang_pkg::ANGLE_ZW-1:0] z_out
);

    localparam int N  = vang_pkg::CORDIC_STEPS;
    localparam int XW = vang_pkg::CORDIC_XW;
    localparam int ZW = vang_pkg::CORDIC_ZW;

    logic signed [XW-1:0] x_reg [N];
    logic signed [XW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];
    logic signed [XW-1:0] x_in  [N];
    logic signed [XW-1:0] y_in  [N];
    logic signed [ZW-1:0] z_in  [N];
    logic [vang_pkg::ANGLE_ZW-1:0] z_out_reg;

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;

        if (i == 0) begin : g_first
            assign x_in[i] = signed'(XW'(c) << vang_pkg::CORDIC_PRESHIFT);
            assign y_in[i] = signed'(XW'(s) << vang_pkg::CORDIC_PRESHIFT);
            assign z_in[i] = '0;
        end else begin : g_next
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
        end

        assign dx = y_in[i] >>> i;
        assign dy = x_in[i] >>> i;
        assign da = signed'(ZW'(vang_pkg::ATAN_DEG_Q16[i]));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_in[i] > 0) begin
                    z_reg[i] <= z_in[i] + da;
                    if (i < N - 1) begin
                        x_reg[i] <= x_in[i] + dx;
                        y_reg[i] <= y_in[i] - dy;
                    end
                end else begin
                    z_reg[i] <= z_in[i] - da;
                    if (i < N - 1) begin
                        x_reg[i] <= x_in[i] - dx;
                        y_reg[i] <= y_in[i] + dy;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_reg[N-1] < 0) begin
                z_out_reg <= '0;
            end else if (z_reg[N-1] > vang_pkg::QUARTER_Q16) begin
                z_out_reg <= vang_pkg::ANGLE_ZW'(vang_pkg::QUARTER_Q16);
            end else begin
                z_out_reg <= vang_pkg::ANGLE_ZW'(z_reg[N-1]);
            end
        end
    end

    assign z_out = z_out_reg;

endmodule

/* hw/rtl/vector_angle_2d.sv */
// ----------------------------------------------------------------------------
// vector_angle_2d: cosine, sine, tangent and angle between two 2D vectors
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_       in   first_x, first_y, second_x, second_y       -
//   m_       out  cosine, sine, tangent, angle_degrees, pad  tangent_infinite,
//                                                            zero_vector
//
// One beat per cycle in and out while m_tready is high. A beat passes
// 2 product and sum stages, MUL_LAT + DIV_LAT + ROOT_W + CORDIC_LAT
// (2 + 35 + 16 + 17) unit stages, set by the bit-per-stage divider, square
// root and CORDIC chains, and then the output queue before it leaves on m_.
// Reset clears only the valid chain and the two-entry output queue.
// The whole pipeline holds while the output queue is full; the queue takes
// one more result while a beat waits on m_tready.
// ----------------------------------------------------------------------------
module vector_angle_2d #(
    parameter int COORD_WIDTH = vang_pkg::COORD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // first_x, first_y, second_x, second_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // cosine, sine, tangent, angle_degrees, zero pad
    output logic [vang_pkg::M_TDATA_W-1:0] m_tdata,
    // tangent_infinite, zero_vector
    output logic [vang_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 4 * W;
    localparam int TOTAL_LAT = 2 + vang_pkg::MUL_LAT + vang_pkg::DIV_LAT
                             + vang_pkg::ROOT_LAT + vang_pkg::CORDIC_LAT;
    localparam int QW  = vang_pkg::M_TDATA_W + vang_pkg::M_TUSER_W;

    logic en;
    logic valid_reg [TOTAL_LAT];

    // stage 1: products
    logic signed [W-1:0]   x1, y1, x2, y2;
    logic signed [2*W-1:0] sxx_reg, syy_reg, sxy_reg, syx_reg;
    logic signed [2*W-1:0] qx1_reg, qy1_reg, qx2_reg, qy2_reg;

    assign x1 = signed'(s_tdata[W-1:0]);
    assign y1 = signed'(s_tdata[2*W-1:W]);
    assign x2 = signed'(s_tdata[3*W-1:2*W]);
    assign y2 = signed'(s_tdata[4*W-1:3*W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            sxx_reg <= x1 * x2;
            syy_reg <= y1 * y2;
            sxy_reg <= x1 * y2;
            syx_reg <= y1 * x2;
            qx1_reg <= x1 * x1;
            qy1_reg <= y1 * y1;
            qx2_reg <= x2 * x2;
            qy2_reg <= y2 * y2;
        end
    end

    // stage 2: lengths, dot and cross magnitudes
    logic [2*W-1:0]      l1_next, l2_next;
    logic signed [2*W:0] d_sum, k_sum;
    logic [2*W:0]        d_abs, k_abs;
    logic [2*W-1:0]      l1_reg, l2_reg, dm_reg, km_reg;
    logic                dneg_reg, dzero_reg, zero_reg;

    assign l1_next = unsigned'(qx1_reg) + unsigned'(qy1_reg);
    assign l2_next = unsigned'(qx2_reg) + unsigned'(qy2_reg);
    assign d_sum   = {sxx_reg[2*W-1], sxx_reg} + {syy_reg[2*W-1], syy_reg};
    assign k_sum   = {sxy_reg[2*W-1], sxy_reg} - {syx_reg[2*W-1], syx_reg};
    assign d_abs   = d_sum[2*W] ? unsigned'(-d_sum) : unsigned'(d_sum);
    assign k_abs   = k_sum[2*W] ? unsigned'(-k_sum) : unsigned'(k_sum);

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg    <= l1_next;
            l2_reg    <= l2_next;
            dm_reg    <= d_abs[2*W-1:0];
            km_reg    <= k_abs[2*W-1:0];
            dneg_reg  <= d_sum[2*W];
            dzero_reg <= d_abs == '0;
            zero_reg  <= (l1_next == '0) || (l2_next == '0);
        end
    end

    // products of lengths and squares
    logic [PW-1:0] lp, dsq, ksq;
    logic [2*W-1:0] dm_m, km_m;

    vang_mul_split #(.HW(W)) u_mul_len (
        .aclk(aclk), .en(en), .a(l1_reg), .b(l2_reg), .p(lp)
    );
    vang_mul_split #(.HW(W)) u_mul_dot (
        .aclk(aclk), .en(en), .a(dm_reg), .b(dm_reg), .p(dsq)
    );
    vang_mul_split #(.HW(W)) u_mul_crs (
        .aclk(aclk), .en(en), .a(km_reg), .b(km_reg), .p(ksq)
    );
    vang_delay #(.WIDTH(4*W), .DEPTH(vang_pkg::MUL_LAT)) u_dly_mag (
        .aclk(aclk), .en(en), .d({dm_reg, km_reg}), .q({dm_m, km_m})
    );

    // dividers
    logic [vang_pkg::DIV_QBITS-1:0] cq, sq, tq;
    logic                           cq_ovf, sq_ovf, tovf;
    logic                           dneg_dv, dzero_dv, zero_dv;

    vang_div #(
        .NW(PW + vang_pkg::COS_SHIFT), .DW(PW), .QB(vang_pkg::DIV_QBITS)
    ) u_div_cos (
        .aclk(aclk), .en(en), .n({dsq, vang_pkg::COS_SHIFT'(0)}), .d(lp),
        .q(cq), .ovf(cq_ovf)
    );
    vang_div #(
        .NW(PW + vang_pkg::COS_SHIFT), .DW(PW), .QB(vang_pkg::DIV_QBITS)
    ) u_div_sin (
        .aclk(aclk), .en(en), .n({ksq, vang_pkg::COS_SHIFT'(0)}), .d(lp),
        .q(sq), .ovf(sq_ovf)
    );
    vang_div #(
        .NW(2*W + vang_pkg::TAN_SHIFT), .DW(2*W), .QB(vang_pkg::DIV_QBITS)
    ) u_div_tan (
        .aclk(aclk), .en(en), .n({km_m, vang_pkg::TAN_SHIFT'(0)}), .d(dm_m),
        .q(tq), .ovf(tovf)
    );
    vang_delay #(.WIDTH(3), .DEPTH(vang_pkg::MUL_LAT + vang_pkg::DIV_LAT)) u_dly_flg (
        .aclk(aclk), .en(en), .d({dneg_reg, dzero_reg, zero_reg}),
        .q({dneg_dv, dzero_dv, zero_dv})
    );

    // tangent rounding and saturation
    logic [vang_pkg::DIV_QBITS:0] t_round;
    logic [vang_pkg::TAN_W-1:0]   t_limit, t_mag, t_val;

    assign t_round = ({1'b0, tq} + 1'b1) >> 1;
    assign t_limit = dneg_dv ? vang_pkg::TAN_NEG_MAX : vang_pkg::TAN_POS_MAX;
    assign t_mag   = (tovf || (t_round > (vang_pkg::DIV_QBITS+1)'(t_limit)))
                   ? t_limit : t_round[vang_pkg::TAN_W-1:0];
    assign t_val   = dzero_dv ? vang_pkg::TAN_POS_MAX
                   : (dneg_dv ? (vang_pkg::TAN_W'(0) - t_mag) : t_mag);

    logic [vang_pkg::TAN_W-1:0] tan_o;
    logic                       dneg_o, dzero_o, zero_o;

    vang_delay #(
        .WIDTH(vang_pkg::TAN_W + 3), .DEPTH(vang_pkg::ROOT_LAT + vang_pkg::CORDIC_LAT)
    ) u_dly_tan (
        .aclk(aclk), .en(en), .d({t_val, dneg_dv, dzero_dv, zero_dv}),
        .q({tan_o, dneg_o, dzero_o, zero_o})
    );

    // square roots
    logic [vang_pkg::ROOT_W-1:0] rc, rs;
    logic [vang_pkg::ROOT_W:0]   rc_up, rs_up;
    logic [vang_pkg::CS_W-1:0]   c_q, s_q, c_o, s_o;

    vang_isqrt #(.RW(vang_pkg::ROOT_W)) u_sqrt_cos (
        .aclk(aclk), .en(en), .v(cq[2*vang_pkg::ROOT_W-1:0]), .root(rc)
    );
    vang_isqrt #(.RW(vang_pkg::ROOT_W)) u_sqrt_sin (
        .aclk(aclk), .en(en), .v(sq[2*vang_pkg::ROOT_W-1:0]), .root(rs)
    );

    assign rc_up = ({1'b0, rc} + 1'b1) >> 1;
    assign rs_up = ({1'b0, rs} + 1'b1) >> 1;
    assign c_q   = rc_up[vang_pkg::CS_W-1:0];
    assign s_q   = rs_up[vang_pkg::CS_W-1:0];

    // angle
    logic [vang_pkg::ANGLE_ZW-1:0] z_o, z_m;
    logic [vang_pkg::ANGLE_ZW-1:0] z_rnd;
    logic                          cneg_o;

    vang_cordic u_cordic (
        .aclk(aclk), .en(en), .c(c_q), .s(s_q), .z_out(z_o)
    );
    vang_delay #(.WIDTH(2*vang_pkg::CS_W), .DEPTH(vang_pkg::CORDIC_LAT)) u_dly_cs (
        .aclk(aclk), .en(en), .d({c_q, s_q}), .q({c_o, s_o})
    );

    // output assembly
    logic [vang_pkg::COS_W-1:0]   cos_f;
    logic [vang_pkg::CS_W-1:0]    sin_f;
    logic [vang_pkg::TAN_W-1:0]   tan_f;
    logic [vang_pkg::ANGLE_W-1:0] ang_f;
    logic                         inf_f;
    logic [QW-1:0]                q_in;

    assign cneg_o = dneg_o && (c_o != '0);
    assign z_m    = cneg_o ? (vang_pkg::ANGLE_ZW'(vang_pkg::HALF_Q16) - z_o) : z_o;
    assign z_rnd  = z_m + vang_pkg::ANGLE_ZW'(vang_pkg::ANGLE_ROUND);

    always_comb begin
        cos_f = '0;
        sin_f = '0;
        tan_f = '0;
        ang_f = '0;
        inf_f = 1'b0;
        if (!zero_o) begin
            cos_f = dneg_o ? (vang_pkg::COS_W'(0) - vang_pkg::COS_W'(c_o))
                           : vang_pkg::COS_W'(c_o);
            sin_f = s_o;
            tan_f = tan_o;
            ang_f = vang_pkg::ANGLE_W'(z_rnd >> vang_pkg::ANGLE_FRAC_DROP);
            inf_f = dzero_o;
        end
    end

    assign q_in = {zero_o, inf_f, 1'b0, ang_f, tan_f, sin_f, cos_f};

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // two-entry output queue
    logic [QW-1:0] qd_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign en       = cnt_reg != 2'd2;
    assign s_tready = en;
    assign push     = en && valid_reg[TOTAL_LAT-1];
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            qd_reg[wr_ptr_reg] <= q_in;
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = qd_reg[rd_ptr_reg][vang_pkg::M_TDATA_W-1:0];
    assign m_tuser  = qd_reg[rd_ptr_reg][QW-1:vang_pkg::M_TDATA_W];

endmodule

/* sim/tb_vector_angle_2d.sv */
// ----------------------------------------------------------------------------
// tb_vector_angle_2d: self-checking bench for the 2D vector angle pipeline
// Drives vector pairs into the stream input and predicts the cosine, sine,
// tangent, angle and flags of every accepted beat in exact integer arithmetic.
// Each output beat is compared against the oldest prediction. The run covers
// directed corner cases, biased random pairs, random stalls on both sides and
// a long output hold that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_vector_angle_2d;

    localparam int CW        = 16;
    localparam int S_TDATA_W = ((4*CW+7)/8)*8;
    localparam int LATENCY   = 72;
    localparam int WDOG_MAX  = 4000;

    typedef struct {
        logic [vang_pkg::COS_W-1:0]   cosine;
        logic [vang_pkg::CS_W-1:0]    sine;
        logic [vang_pkg::TAN_W-1:0]   tangent;
        logic [vang_pkg::ANGLE_W-1:0] angle;
        logic                         tan_inf;
        logic                         zero_vec;
    } angle_res_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_TDATA_W-1:0]           s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [vang_pkg::M_TDATA_W-1:0] m_tdata;
    logic [vang_pkg::M_TUSER_W-1:0] m_tuser;

    angle_res_t pending_results[$];
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_errors = 0;
    int         n_zero = 0;
    int         n_perp = 0;
    bit         idle_on = 1'b0;
    int         hold_reqs = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         hold_len = 0;
    int         quiet_cycles = 0;

    vector_angle_2d #(.COORD_WIDTH(CW)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // floor(16384*num/sqrt(l1*l2) + 1/2) by bisection on squared terms
    function automatic logic [vang_pkg::CS_W-1:0] ratio_q14(longint unsigned num,
                                                            longint unsigned l1,
                                                            longint unsigned l2);
        logic [127:0]    prod;
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        longint unsigned k;
        prod = 128'(l1) * 128'(l2);
        rhs  = (128'(num) * 128'(num)) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k   = 2 * longint'(mid) - 1;
            lhs = prod * 128'(k * k);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return vang_pkg::CS_W'(lo);
    endfunction

    function automatic logic [vang_pkg::TAN_W-1:0] tangent_q16(longint unsigned a,
                                                              longint unsigned b,
                                                              bit neg);
        longint unsigned limit;
        longint unsigned t;
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (a / b >= 64'd65536) begin
            t = limit;
        end else begin
            t = (((a << 17) / b) + 1) >> 1;
            if (t > limit) t = limit;
        end
        return neg ? vang_pkg::TAN_W'(-t) : vang_pkg::TAN_W'(t);
    endfunction

    function automatic logic [vang_pkg::ANGLE_W-1:0] angle_q88(longint c, bit cneg,
                                                              longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = c * 1024;
        y = s * 1024;
        z = 0;
        for (int i = 0; i < vang_pkg::CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(vang_pkg::ATAN_DEG_Q16[i]);
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(vang_pkg::ATAN_DEG_Q16[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > vang_pkg::QUARTER_Q16) z = vang_pkg::QUARTER_Q16;
        if (cneg) z = vang_pkg::HALF_Q16 - z;
        return vang_pkg::ANGLE_W'((z + 128) >>> 8);
    endfunction

    function automatic angle_res_t predict_angle(logic [S_TDATA_W-1:0] d);
        angle_res_t      r;
        longint          x1;
        longint          y1;
        longint          x2;
        longint          y2;
        longint          dot;
        longint          crs;
        longint unsigned l1;
        longint unsigned l2;
        longint unsigned dm;
        longint unsigned km;
        longint          c;
        longint          s;
        bit              dneg;
        x1 = longint'($signed(d[15:0]));
        y1 = longint'($signed(d[31:16]));
        x2 = longint'($signed(d[47:32]));
        y2 = longint'($signed(d[63:48]));
        l1 = x1*x1 + y1*y1;
        l2 = x2*x2 + y2*y2;
        dot = x1*x2 + y1*y2;
        crs = x1*y2 - y1*x2;
        dneg = dot < 0;
        dm = dneg ? -dot : dot;
        km = crs < 0 ? -crs : crs;
        r = '{default: '0};
        if (l1 == 0 || l2 == 0) begin
            r.zero_vec = 1'b1;
            return r;
        end
        c = longint'(ratio_q14(dm, l1, l2));
        s = longint'(ratio_q14(km, l1, l2));
        r.cosine = dneg ? vang_pkg::COS_W'(-c) : vang_pkg::COS_W'(c);
        r.sine   = vang_pkg::CS_W'(s);
        if (dm == 0) begin
            r.tangent = vang_pkg::TAN_POS_MAX;
            r.tan_inf = 1'b1;
        end else begin
            r.tangent = tangent_q16(km, dm, dneg);
        end
        r.angle = angle_q88(c, dneg && c != 0, s);
        return r;
    endfunction

    // record a prediction for every accepted input beat
    always @(posedge aclk) begin
        angle_res_t p;
        if (aresetn && s_tvalid && s_tready) begin
            p = predict_angle(s_tdata);
            if (p.zero_vec) n_zero++;
            if (p.tan_inf) n_perp++;
            pending_results.push_back(p);
            n_sent++;
        end
    end

    task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        angle_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h/%h",
                         $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[15:0] !== e.cosine)
                    report_field("cosine", 64'(e.cosine), 64'(m_tdata[15:0]));
                if (m_tdata[30:16] !== e.sine)
                    report_field("sine", 64'(e.sine), 64'(m_tdata[30:16]));
                if (m_tdata[62:31] !== e.tangent)
                    report_field("tangent", 64'(e.tangent), 64'(m_tdata[62:31]));
                if (m_tdata[78:63] !== e.angle)
                    report_field("angle_degrees", 64'(e.angle), 64'(m_tdata[78:63]));
                if (m_tuser[0] !== e.tan_inf)
                    report_field("tangent_infinite", 64'(e.tan_inf), 64'(m_tuser[0]));
                if (m_tuser[1] !== e.zero_vec)
                    report_field("zero_vector", 64'(e.zero_vec), 64'(m_tuser[1]));
                n_checked++;
            end
        end
    end

    // output side: random stalls plus requested long holds
    always @(posedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_on) begin
            m_tready <= ($urandom_range(99) >= 29);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_vectors(logic [15:0] x1, logic [15:0] y1,
                                logic [15:0] x2, logic [15:0] y2);
        while (idle_on && ($urandom_range(99) < 29)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y2, x2, y1, x1};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] corner_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    task automatic send_random_pair();
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        int          m;
        int          sel;
        x1 = 16'($urandom);
        y1 = 16'($urandom);
        x2 = 16'($urandom);
        y2 = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 20) begin
            x1 = 16'($signed($urandom_range(16)) - 8);
            y1 = 16'($signed($urandom_range(16)) - 8);
            x2 = 16'($signed($urandom_range(16)) - 8);
            y2 = 16'($signed($urandom_range(16)) - 8);
        end else if (sel < 35) begin
            x1 = corner_coord();
            y1 = corner_coord();
            x2 = corner_coord();
            y2 = corner_coord();
        end else if (sel < 45) begin
            m  = $urandom_range(1, 3);
            x1 = 16'($signed($urandom_range(20000)) - 10000);
            y1 = 16'($signed($urandom_range(20000)) - 10000);
            x2 = 16'(-m * $signed(y1));
            y2 = 16'(m * $signed(x1));
        end else if (sel < 55) begin
            m  = $signed($urandom_range(6)) - 3;
            x1 = 16'($signed($urandom_range(20000)) - 10000);
            y1 = 16'($signed($urandom_range(20000)) - 10000);
            x2 = 16'(m * $signed(x1) + $signed($urandom_range(2)) - 1);
            y2 = 16'(m * $signed(y1));
        end else if (sel < 60) begin
            if ($urandom_range(1)) begin
                x1 = '0;
                y1 = '0;
            end else begin
                x2 = '0;
                y2 = '0;
            end
        end
        send_vectors(x1, y1, x2, y2);
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        send_vectors(16'd0, 16'd0, 16'd5, 16'd7);
        send_vectors(16'd3, 16'hFFFC, 16'd0, 16'd0);
        send_vectors(16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd1, 16'd0, 16'd1, 16'd0);
        send_vectors(16'd1, 16'd0, 16'hFFFF, 16'd0);
        send_vectors(16'd1, 16'd0, 16'd0, 16'd1);
        send_vectors(16'd0, 16'h8000, 16'h7FFF, 16'd0);
        send_vectors(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vectors(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vectors(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_vectors(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_vectors(16'h8000, 16'd0, 16'h7FFF, 16'd0);
        send_vectors(16'h7FFF, 16'd0, 16'h7FFF, 16'd1);
        send_vectors(16'h7FFF, 16'd0, 16'hFFFF, 16'h7FFF);
        send_vectors(16'd32767, 16'd32766, 16'($signed(-32765)), 16'd32766);
        send_vectors(16'd32767, 16'd32766, 16'd32765, 16'($signed(-32766)));
        send_vectors(16'd1, 16'd1, 16'd1, 16'd0);
        send_vectors(16'd1, 16'd1, 16'hFFFF, 16'd0);
        send_vectors(16'd3, 16'd4, 16'hFFFC, 16'd3);
        send_vectors(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);
        stop_sending();
        drain_results();
    endtask

    task automatic test_random_steady();
        idle_on = 1'b0;
        repeat (200) send_random_pair();
        stop_sending();
    endtask

    task automatic test_random_stalls();
        idle_on = 1'b1;
        repeat (400) send_random_pair();
        stop_sending();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_len = 400;
        hold_reqs++;
        repeat (150) send_random_pair();
        stop_sending();
        drain_results();
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_steady();
        test_random_stalls();
        test_backpressure();
        drain_results();
        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d vector pairs, %0d beats checked", n_sent, n_checked);
        $display("zero-length cases %0d, perpendicular cases %0d", n_zero, n_perp);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
